[src/duplicate_frame_filter_top_macros.svh]
// Assertion macros for the duplicate frame filter history module.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef DUPLICATE_FRAME_FILTER_TOP_MACROS_SVH
`define DUPLICATE_FRAME_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define DUPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DUPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dupf_pkg.sv]
// Shared constants and types for the duplicate frame filter.
// No dependencies.
package dupf_pkg;
	localparam int HISTORY_DEPTH = 128;
	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int WIN_W = 8;
	localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
	localparam int CTR_W = 32;
	localparam int TYPE_W = 8;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd100;
	localparam logic [TYPE_W-1:0] REPLY_FRAME_TYPE = 8'd2;

	typedef struct packed {
		logic             valid;
		logic [CTR_W-1:0] counter;
	} lookup_req_t;
endpackage

[src/dupf_history.sv]
// History of recent distinct frame counters: parallel lookup and update.
// Depends on dupf_pkg and duplicate_frame_filter_top_macros.svh.
`include "duplicate_frame_filter_top_macros.svh"
module dupf_history import dupf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WIN_W-1:0]  window,
	input  lookup_req_t       req,
	output logic              hit
);
	logic [CTR_W-1:0] history_q [HISTORY_DEPTH];
	logic [CNT_W-1:0] held_q;
	logic [IDX_W-1:0] oldest_q;
	logic [HISTORY_DEPTH-1:0] match;

	logic [CMP_W-1:0] eff_win, held_ext, held1_ext;
	logic             evict, append;
	logic [CNT_W-1:0] held1, held_next;
	logic [IDX_W-1:0] oldest1;
	logic [IDX_W:0]   slot_sum;
	logic [IDX_W-1:0] wr_slot;

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			logic [IDX_W:0] offs;
			offs = (IDX_W+1)'(i) - {1'b0, oldest_q};
			if (IDX_W'(i) < oldest_q) begin
				offs = offs + (IDX_W+1)'(HISTORY_DEPTH);
			end
			match[i] = (CNT_W'(offs) < held_q) && (history_q[i] == req.counter);
		end
	end

	assign hit = |match;

	always_comb begin
		if (CMP_W'(window) > CMP_W'(HISTORY_DEPTH)) begin
			eff_win = CMP_W'(HISTORY_DEPTH);
		end else begin
			eff_win = CMP_W'(window);
		end
		held_ext = CMP_W'(held_q);
		evict = (held_ext >= eff_win) && (held_q != '0);
		held1 = held_q - CNT_W'(evict);
		if (evict && (oldest_q == IDX_W'(HISTORY_DEPTH - 1))) begin
			oldest1 = '0;
		end else begin
			oldest1 = oldest_q + IDX_W'(evict);
		end
		held1_ext = CMP_W'(held1);
		append = held1_ext < eff_win;
		held_next = held1 + CNT_W'(append);
		slot_sum = {1'b0, oldest1} + (IDX_W+1)'(held1);
		if (slot_sum >= (IDX_W+1)'(HISTORY_DEPTH)) begin
			slot_sum = slot_sum - (IDX_W+1)'(HISTORY_DEPTH);
		end
		wr_slot = slot_sum[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			oldest_q <= '0;
		end else if (req.valid && !hit) begin
			held_q   <= held_next;
			oldest_q <= oldest1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && !hit && append) begin
			history_q[wr_slot] <= req.counter;
		end
	end

	`DUPF_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_W'(HISTORY_DEPTH), "held count above depth")
	`DUPF_ASSERT_NEXT(a_repeat_keeps, req.valid && hit, $stable(held_q) && $stable(oldest_q), "repeat changed history")
	`DUPF_ASSERT_NEXT(a_new_kept, req.valid && !hit && (window != '0), held_q != '0, "new counter not kept")
endmodule

[src/duplicate_frame_filter_top.sv]
// Duplicate frame filter: each input transaction is captured in stage s1, its result in s2.
// Throughput one frame header per cycle unless m_tready stalls the output; lookup compares
// all history entries at once and the history updates in the same cycle, so the next header sees it.
// Reset clears the history fill count, oldest pointer and window length (to 100);
// history contents are not cleared, no clearing pass.
// Depends on dupf_pkg and dupf_history.
module duplicate_frame_filter_top import dupf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] frame_counter, [39:32] frame_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] is_repeat, [1] need_reply, [2] forward, [7:3] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // window_length
);
	logic [WIN_W-1:0]  window_q;
	logic              valid_s1;
	logic [CTR_W-1:0]  counter_s1;
	logic [TYPE_W-1:0] type_s1;
	logic              valid_s2;
	logic              repeat_s2, reply_s2;
	logic              advance, hit;
	lookup_req_t       req;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid) begin
			window_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			counter_s1 <= s_tdata[CTR_W-1:0];
			type_s1    <= s_tdata[CTR_W+TYPE_W-1:CTR_W];
		end
		if (advance) begin
			repeat_s2 <= hit;
			reply_s2  <= (type_s1 == REPLY_FRAME_TYPE);
		end
	end

	assign req.valid   = advance;
	assign req.counter = counter_s1;

	dupf_history u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.window (window_q),
		.req    (req),
		.hit    (hit)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, !repeat_s2, reply_s2, repeat_s2};
endmodule
